// ===== design/ctcgd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctcgd_pkg - shared types and constants of the greedy CTC decoder
// Result kinds, header token count, batch depth and the blank field width.
// ----------------------------------------------------------------------------
package ctcgd_pkg;

  // Width of the blank register, fixed by the register map
  localparam int unsigned BlankBits = 15;

  // Number of leading tokens of an utterance reported as header tokens
  localparam int unsigned HeaderTokens = 4;

  // Most results that one item can give rise to
  localparam int unsigned BatchDepth = 5;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_STAMP  = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e;

endpackage

// ===== design/ctcgd_in_if.sv =====
// ----------------------------------------------------------------------------
// ctcgd_in_if - class score channel
// One class score per item, with frame and utterance end flags.
// ----------------------------------------------------------------------------
interface ctcgd_in_if #(
  parameter int unsigned SCORE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [SCORE_BITS-1:0] logit;
  logic                  frame_end;
  logic                  utterance_end;

  modport source (output valid, output logit, output frame_end, output utterance_end,
                  input ready);
  modport sink   (input valid, input logit, input frame_end, input utterance_end,
                  output ready);
endinterface

// ===== design/ctcgd_out_if.sv =====
// ----------------------------------------------------------------------------
// ctcgd_out_if - decoder result channel
// One result per item: kind, token, frame stamp and last flag.
// ----------------------------------------------------------------------------
interface ctcgd_out_if #(
  parameter int unsigned TOKEN_BITS = 15,
  parameter int unsigned FRAME_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [TOKEN_BITS-1:0] token_id;
  logic [FRAME_BITS-1:0] frame_index;
  logic                  last;

  modport source (output valid, output kind, output token_id, output frame_index,
                  output last, input ready);
  modport sink   (input valid, input kind, input token_id, input frame_index,
                  input last, output ready);
endinterface

// ===== design/ctcgd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ctcgd_cfg_if - configuration write channel
// Carries the blank token register value.
// ----------------------------------------------------------------------------
interface ctcgd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ctcgd_pkg::BlankBits-1:0]    blank_token;

  modport source (output valid, output blank_token, input ready);
  modport sink   (input valid, input blank_token, output ready);
endinterface

// ===== design/ctc_greedy_decoder.sv =====
// ----------------------------------------------------------------------------
// ctc_greedy_decoder - streaming greedy CTC decoder
// Running per-frame argmax, CTC collapse, header/text tokens and frame stamps.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : class scores, one per item, frame after frame. frame_end marks the
//           last score of a frame; utterance_end with frame_end closes the
//           utterance.
//   out_o : results (header token, text token, time stamp, done), each with
//           last set on the final result caused by one input item.
//   cfg_i : blank token register, always ready; write only while idle.
// Timing: an item is taken in every cycle while no results are pending. A
//   frame end builds its whole batch (up to five results) in the accept cycle;
//   the batch is registered in the slot registers, and each result is then
//   popped into the output register and shown on out_o, one per cycle while
//   the receiver is ready. The next item is accepted in the cycle the last
//   pending result moves into the output register, so the drain rate of the
//   output register sets the input rate after a frame end.
// Reset: argmax, frame counter, span and header state cleared, blank = 0, no
//   results pending. A stalled receiver holds out_o; while results are
//   pending, in_i ready stays low until the batch drains.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder #(
  parameter int unsigned TOKEN_BITS = 15,
  parameter int unsigned SCORE_BITS = 16,
  parameter int unsigned FRAME_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctcgd_in_if.sink    in_i,
  ctcgd_out_if.source out_o,
  ctcgd_cfg_if.sink   cfg_i
);

  localparam int unsigned BlankW = ctcgd_pkg::BlankBits;
  localparam int unsigned CmpW   = (TOKEN_BITS > BlankW) ? TOKEN_BITS : BlankW;
  localparam int unsigned Depth  = ctcgd_pkg::BatchDepth;
  localparam int unsigned CntW   = $clog2(Depth + 1);

  typedef struct packed {
    ctcgd_pkg::kind_e      kind;
    logic [TOKEN_BITS-1:0] tok;
    logic [FRAME_BITS-1:0] frame;
  } slot_t;

  localparam logic [SCORE_BITS-1:0] ScoreMin = {1'b1, {(SCORE_BITS-1){1'b0}}};

  // ---------------- configuration ----------------
  logic [BlankW-1:0] blank_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= '0;
    end else if (cfg_i.valid) begin
      blank_q <= cfg_i.blank_token;
    end
  end

  // ---------------- decoder state ----------------
  logic [SCORE_BITS-1:0] best_score_q, best_score_d;
  logic [TOKEN_BITS-1:0] best_idx_q, best_idx_d;
  logic [TOKEN_BITS-1:0] class_q, class_d;
  logic [TOKEN_BITS-1:0] prev_tok_q, prev_tok_d;
  logic                  prev_vld_q, prev_vld_d;
  logic                  span_q, span_d;
  logic [2:0]            hdr_cnt_q, hdr_cnt_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;

  // ---------------- result batch and output register ----------------
  slot_t                 slot_q [Depth];
  slot_t                 slot_d [Depth];
  logic [CntW-1:0]       rem_q, rem_d;
  logic                  out_vld_q, out_vld_d;
  slot_t                 out_q;
  logic                  out_last_q;

  logic                  acc;
  logic                  pop;
  logic                  gt;
  logic [TOKEN_BITS-1:0] y;
  logic                  is_blank;
  logic                  is_new;
  logic                  hdr_full;
  logic                  close_span;
  logic                  span_after;
  logic [2:0]            hdr_after;
  logic                  cand_vld [Depth];
  slot_t                 cand     [Depth];
  slot_t                 batch    [Depth];
  logic [CntW-1:0]       batch_n;

  // Pop the batch head into the output register when that register is free
  assign pop         = (rem_q != '0) && (!out_vld_q || out_o.ready);
  // Take an item once the batch is empty, or is being emptied this cycle
  assign in_i.ready  = (rem_q == '0) || ((rem_q == CntW'(1)) && pop);
  assign acc         = in_i.valid && in_i.ready;

  // Running argmax: strict greater, so a tie keeps the lower index
  assign gt = $signed(in_i.logit) > $signed(best_score_q);
  assign y  = gt ? class_q : best_idx_q;

  // Blank compared at full width: a blank beyond the token range never hits
  assign is_blank   = (CmpW'(y) == CmpW'(blank_q));
  assign is_new     = !is_blank && (!prev_vld_q || (y != prev_tok_q));
  assign hdr_full   = (hdr_cnt_q >= 3'(ctcgd_pkg::HeaderTokens));
  assign close_span = span_q && (is_blank || is_new);

  always_comb begin
    span_after = span_q;
    if (close_span) begin
      span_after = 1'b0;
    end
    if (is_new && hdr_full) begin
      span_after = 1'b1;
    end
    hdr_after = hdr_cnt_q;
    if (is_new && !hdr_full) begin
      hdr_after = hdr_cnt_q + 3'd1;
    end
  end

  // Candidate results of a frame end, in delivery order
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      cand[i].kind  = ctcgd_pkg::KIND_STAMP;
      cand[i].tok   = '0;
      cand[i].frame = frame_q;
    end
    cand[1].kind = hdr_full ? ctcgd_pkg::KIND_TEXT : ctcgd_pkg::KIND_HEADER;
    cand[1].tok  = y;
    cand[4].kind = ctcgd_pkg::KIND_DONE;

    cand_vld[0] = close_span;                             // end stamp of old span
    cand_vld[1] = is_new;                                 // header or text token
    cand_vld[2] = is_new && hdr_full;                     // start stamp
    cand_vld[3] = in_i.utterance_end && span_after;       // closing end stamp
    cand_vld[4] = in_i.utterance_end;                     // done marker
  end

  // Pack the valid candidates to the front of the batch
  always_comb begin
    batch_n = '0;
    for (int i = 0; i < Depth; i++) begin
      batch[i] = cand[Depth-1];
    end
    for (int i = 0; i < Depth; i++) begin
      if (cand_vld[i]) begin
        batch[batch_n[$clog2(Depth)-1:0]] = cand[i];
        batch_n = batch_n + CntW'(1);
      end
    end
  end

  // Next state of the decoder
  always_comb begin
    best_score_d = best_score_q;
    best_idx_d   = best_idx_q;
    class_d      = class_q;
    prev_tok_d   = prev_tok_q;
    prev_vld_d   = prev_vld_q;
    span_d       = span_q;
    hdr_cnt_d    = hdr_cnt_q;
    frame_d      = frame_q;
    if (acc) begin
      if (!in_i.frame_end) begin
        if (gt) begin
          best_score_d = in_i.logit;
        end
        best_idx_d = y;
        class_d    = TOKEN_BITS'(class_q + 1'b1);
      end else begin
        best_score_d = ScoreMin;
        best_idx_d   = '0;
        class_d      = '0;
        if (in_i.utterance_end) begin
          prev_tok_d = '0;
          prev_vld_d = 1'b0;
          span_d     = 1'b0;
          hdr_cnt_d  = '0;
          frame_d    = '0;
        end else begin
          prev_tok_d = y;
          prev_vld_d = 1'b1;
          span_d     = span_after;
          hdr_cnt_d  = hdr_after;
          frame_d    = FRAME_BITS'(frame_q + 1'b1);
        end
      end
    end
  end

  // Batch: load on a frame end, else shift down on pop
  always_comb begin
    rem_d = rem_q;
    for (int i = 0; i < Depth; i++) begin
      slot_d[i] = slot_q[i];
    end
    if (acc && in_i.frame_end) begin
      rem_d = batch_n;
      for (int i = 0; i < Depth; i++) begin
        slot_d[i] = batch[i];
      end
    end else if (pop) begin
      rem_d = rem_q - CntW'(1);
      for (int i = 0; i < Depth - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q <= ScoreMin;
      best_idx_q   <= '0;
      class_q      <= '0;
      prev_tok_q   <= '0;
      prev_vld_q   <= 1'b0;
      span_q       <= 1'b0;
      hdr_cnt_q    <= '0;
      frame_q      <= '0;
      rem_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      best_score_q <= best_score_d;
      best_idx_q   <= best_idx_d;
      class_q      <= class_d;
      prev_tok_q   <= prev_tok_d;
      prev_vld_q   <= prev_vld_d;
      span_q       <= span_d;
      hdr_cnt_q    <= hdr_cnt_d;
      frame_q      <= frame_d;
      rem_q        <= rem_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
    if (pop) begin
      out_q      <= slot_q[0];
      out_last_q <= (rem_q == CntW'(1));
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.token_id    = out_q.tok;
  assign out_o.frame_index = out_q.frame;
  assign out_o.last        = out_last_q;

endmodule
